// ----- rtl/kwm_pkg.sv -----
// Shared types and constants for the k-way merge heap.
package kwm_pkg;

    localparam int ACT_BITS    = 2;
    localparam int STREAM_BITS = 4;
    localparam int COUNT_BITS  = 5;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd16;

    // Input item action codes
    localparam logic [ACT_BITS-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_REFILL = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_END    = 2'd2;

    // Result of one compare step of the sift-down
    typedef struct packed {
        logic swap;        // parent is strictly greater than a child
        logic pick_right;  // move the right child up, not the left one
    } t_cmp_res;

endpackage

// ----- rtl/kwm_ram.sv -----
// Heap storage: one write port and two registered read ports.
module kwm_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 36
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [DW-1:0] i_wd,
    input  logic [AW-1:0] i_ra_a,
    input  logic [AW-1:0] i_ra_b,
    output logic [DW-1:0] o_rd_a,
    output logic [DW-1:0] o_rd_b
);

    logic [DW-1:0] r_mem [DEPTH];

    // Write one entry, read two
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd_a <= r_mem[i_ra_a];
        o_rd_b <= r_mem[i_ra_b];
    end

endmodule

// ----- rtl/kwm_cmp.sv -----
// Shared compare unit: decides one sift-down step from parent and children keys.
module kwm_cmp #(
    parameter int VALUE_BITS = 32
) (
    input  logic [VALUE_BITS-1:0] i_cur,
    input  logic [VALUE_BITS-1:0] i_left,
    input  logic [VALUE_BITS-1:0] i_right,
    input  logic                  i_right_ok,
    output kwm_pkg::t_cmp_res     o_res
);

    // Keys are order keys (sign flipped), so unsigned compares suffice
    always_comb begin
        o_res.swap       = (i_cur > i_left) || (i_right_ok && (i_cur > i_right));
        // right child wins ties
        o_res.pick_right = i_right_ok && !(i_left < i_right);
    end

endmodule

// ----- rtl/k_way_merge_heap.sv -----
// Top level of the k-way merge heap: sequencer around heap memory and compare unit.
// A load that does not complete the set gives no result and leaves the sequencer idle.
// Refill: the new head is sifted down from the root, each step checked (ST_S_CHK) and compared
// (ST_S_CMP) until it settles, then ST_S_END and ST_EMIT; end first loads the last entry in ST_B_LD.
// Heap build on the final load: each interior node, last to root, is read (ST_B_RD, ST_B_LD)
// and sifted down the same way; then ST_EMIT moves the root to the output register.
// One item at a time; throughput is set by the single compare unit and memory read port pair.
// Reset (synchronous, active low) returns to the loading phase with an empty heap.
module k_way_merge_heap #(
    parameter int MAX_STREAMS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [kwm_pkg::COUNT_BITS-1:0]      i_cfg_data,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [kwm_pkg::ACT_BITS-1:0]        i_action,
    input  logic signed [VALUE_BITS-1:0]        i_value,
    input  logic [kwm_pkg::STREAM_BITS-1:0]     i_stream,
    input  logic                                i_empty_req,
    // results
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [VALUE_BITS-1:0]        o_min_value,
    output logic [kwm_pkg::STREAM_BITS-1:0]     o_source,
    output logic                                o_done_res
);

    localparam int IW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int SW = $clog2(MAX_STREAMS + 1);
    localparam int SB = kwm_pkg::STREAM_BITS;
    localparam int DW = VALUE_BITS + SB;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_B_RD,
        ST_B_LD,
        ST_S_CHK,
        ST_S_CMP,
        ST_S_END,
        ST_EMIT
    } t_state;

    t_state                r_state;
    logic [kwm_pkg::COUNT_BITS-1:0] r_count;
    logic [SW-1:0]         r_size;
    logic [SW-1:0]         r_loads;
    logic                  r_merging;
    logic                  r_build;
    logic                  r_pend_done;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_at;
    logic [DW-1:0]         r_cur;
    logic [DW-1:0]         r_root;

    logic                  acc;
    logic [VALUE_BITS-1:0] in_key;
    logic [SW-1:0]         need;
    logic [SW-1:0]         size_new;
    logic [SW-1:0]         loads_new;
    logic [SW-1:0]         half_new;
    logic [SW-1:0]         at_w;
    logic [SW-1:0]         child_l;
    logic [SW-1:0]         child_r;
    logic                  descend;
    logic                  right_ok;

    logic                  mem_we;
    logic [IW-1:0]         mem_wa;
    logic [DW-1:0]         mem_wd;
    logic [IW-1:0]         mem_ra_a;
    logic [IW-1:0]         mem_ra_b;
    logic [DW-1:0]         mem_rd_a;
    logic [DW-1:0]         mem_rd_b;
    kwm_pkg::t_cmp_res     cmp_res;

    assign o_in_ready = (r_state == ST_IDLE);
    assign acc        = i_in_valid && o_in_ready;

    // Order key: flip the sign bit so unsigned order matches signed order
    assign in_key = {~i_value[VALUE_BITS-1], i_value[VALUE_BITS-2:0]};

    // Loads needed before merging: zero counts as one, saturate at capacity
    always_comb begin
        if (r_count == '0) begin
            need = SW'(1);
        end else if (int'(r_count) > MAX_STREAMS) begin
            need = SW'(MAX_STREAMS);
        end else begin
            need = SW'(r_count);
        end
    end

    // Heap size and load count after an accepted load
    always_comb begin
        size_new  = r_size;
        loads_new = r_loads;
        if (!i_empty_req && (int'(r_size) < MAX_STREAMS)) begin
            size_new = SW'(r_size + SW'(1));
        end
        if (int'(r_loads) < MAX_STREAMS) begin
            loads_new = SW'(r_loads + SW'(1));
        end
        half_new = size_new >> 1;
    end

    // Child positions of the node being sifted
    assign at_w     = SW'(r_at);
    assign child_l  = SW'((at_w << 1) + SW'(1));
    assign child_r  = SW'((at_w << 1) + SW'(2));
    assign descend  = (at_w < (r_size >> 1));
    assign right_ok = (child_r < r_size);

    kwm_cmp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_cmp (
        .i_cur      (r_cur[DW-1:SB]),
        .i_left     (mem_rd_a[DW-1:SB]),
        .i_right    (mem_rd_b[DW-1:SB]),
        .i_right_ok (right_ok),
        .o_res      (cmp_res)
    );

    // Memory port control
    always_comb begin
        mem_we   = 1'b0;
        mem_wa   = r_at;
        mem_wd   = r_cur;
        mem_ra_a = child_l[IW-1:0];
        mem_ra_b = child_r[IW-1:0];
        case (r_state)
            ST_IDLE: begin
                // fetch the last entry for an end item
                mem_ra_a = IW'(r_size - SW'(1));
                if (acc && !r_merging && (i_action == kwm_pkg::ACT_LOAD) &&
                    !i_empty_req && (int'(r_size) < MAX_STREAMS)) begin
                    mem_we = 1'b1;
                    mem_wa = r_size[IW-1:0];
                    mem_wd = {in_key, i_stream};
                end
            end
            ST_B_RD: begin
                mem_ra_a = r_idx;
            end
            ST_S_CHK: begin
                // settle the element here when it has no children left
                mem_we = !descend;
            end
            ST_S_CMP: begin
                mem_we = 1'b1;
                if (cmp_res.swap) begin
                    mem_wd = cmp_res.pick_right ? mem_rd_b : mem_rd_a;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    kwm_ram #(
        .DEPTH (MAX_STREAMS),
        .AW    (IW),
        .DW    (DW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_wa   (mem_wa),
        .i_wd   (mem_wd),
        .i_ra_a (mem_ra_a),
        .i_ra_b (mem_ra_b),
        .o_rd_a (mem_rd_a),
        .o_rd_b (mem_rd_b)
    );

    // Sequencer, heap bookkeeping and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= kwm_pkg::COUNT_RESET;
            r_size      <= '0;
            r_loads     <= '0;
            r_merging   <= 1'b0;
            r_build     <= 1'b0;
            r_pend_done <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end

            // track the root: any write to position zero
            if (mem_we && (mem_wa == '0)) begin
                r_root <= mem_wd;
            end

            // drop the result once its transfer completes, unless a new one replaces it
            if (o_out_valid && i_out_ready && (r_state != ST_EMIT)) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (acc && !r_merging && (i_action == kwm_pkg::ACT_LOAD)) begin
                        if ((loads_new >= need) && (size_new == '0)) begin
                            // every stream was empty: report done and start over
                            r_pend_done <= 1'b1;
                            r_size      <= '0;
                            r_loads     <= '0;
                            r_state     <= ST_EMIT;
                        end else begin
                            r_size  <= size_new;
                            r_loads <= loads_new;
                            if (loads_new >= need) begin
                                r_idx   <= (half_new == '0) ? '0 : IW'(half_new - SW'(1));
                                r_build <= 1'b1;
                                r_state <= ST_B_RD;
                            end
                        end
                    end else if (acc && r_merging && (i_action == kwm_pkg::ACT_REFILL)) begin
                        // new head keeps the root's stream
                        r_cur   <= {in_key, r_root[SB-1:0]};
                        r_at    <= '0;
                        r_build <= 1'b0;
                        r_state <= ST_S_CHK;
                    end else if (acc && r_merging && (i_action == kwm_pkg::ACT_END)) begin
                        if (r_size <= SW'(1)) begin
                            r_pend_done <= 1'b1;
                            r_size      <= '0;
                            r_loads     <= '0;
                            r_merging   <= 1'b0;
                            r_state     <= ST_EMIT;
                        end else begin
                            r_size  <= SW'(r_size - SW'(1));
                            r_idx   <= '0;
                            r_build <= 1'b0;
                            r_state <= ST_B_LD;
                        end
                    end
                end
                ST_B_RD: begin
                    r_state <= ST_B_LD;
                end
                ST_B_LD: begin
                    r_cur   <= mem_rd_a;
                    r_at    <= r_idx;
                    r_state <= ST_S_CHK;
                end
                ST_S_CHK: begin
                    r_state <= descend ? ST_S_CMP : ST_S_END;
                end
                ST_S_CMP: begin
                    if (cmp_res.swap) begin
                        r_at    <= cmp_res.pick_right ? child_r[IW-1:0] : child_l[IW-1:0];
                        r_state <= ST_S_CHK;
                    end else begin
                        r_state <= ST_S_END;
                    end
                end
                ST_S_END: begin
                    if (r_build && (r_idx != '0)) begin
                        r_idx   <= IW'(r_idx - IW'(1));
                        r_state <= ST_B_RD;
                    end else begin
                        if (r_build) begin
                            r_merging <= 1'b1;
                        end
                        r_pend_done <= 1'b0;
                        r_state     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // hold until the output register is free
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid <= 1'b1;
                        if (r_pend_done) begin
                            o_min_value <= '0;
                            o_source    <= '0;
                            o_done_res  <= 1'b1;
                        end else begin
                            o_min_value <= {~r_root[DW-1], r_root[DW-2:SB]};
                            o_source    <= r_root[SB-1:0];
                            o_done_res  <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Compare step only runs on a node whose left child is inside the heap
    a_left_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_S_CMP) |-> (child_l < r_size))
        else $error("sift compare on a leaf");

    // Heap never grows past capacity
    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_size) <= MAX_STREAMS)
        else $error("heap size beyond capacity");

    // While merging and idle the heap holds at least one entry
    a_merge_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_merging && (r_state == ST_IDLE)) |-> (r_size != '0))
        else $error("merging with an empty heap");

    // A load during merging leaves the heap untouched
    a_load_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_merging && (i_action == kwm_pkg::ACT_LOAD)) |=>
        ($stable(r_size) && (r_state == ST_IDLE)))
        else $error("load accepted while merging");

endmodule
